### hdl/qcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcg_pkg
// Shared constants and types of the quadratic congruential bit generator:
// the fixed reset seed, operation codes, controller states and the control
// bundle of the bit-serial multiplier.
// ----------------------------------------------------------------------------
package qcg_pkg;

   localparam int STATE_BITS_DEFAULT = 512;
   localparam int WORD_BITS          = 64;
   localparam int MAX_STATE_BITS     = 1024;

   // fixed seed, zero extended; a narrower state keeps its low words
   localparam logic [MAX_STATE_BITS-1:0] SEED_VALUE = {
      512'd0,
      64'h7844506a9456c564, 64'hb8b8538e0cc15aff,
      64'h46c95e69600f084f, 64'h0657c2401b3c2447,
      64'h34b62ea9bb95be49, 64'h23b9b7e84eeaf1a2,
      64'h24894ef0328d44bc, 64'h3eb3e983644da3f5
   };

   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_SEED    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } fsm_type;

   typedef struct packed {
      logic clear;
      logic step;
   } mult_ctrl_type;

endpackage
`default_nettype wire

### hdl/quadratic_congruential_prng_512.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_congruential_prng_512
// Quadratic congruential bit generator, x <- 2x^2 + 3x + 1 mod 2^STATE_BITS.
//
// Input channel (req_): operation 0 advances the state and emits one block,
// operation 1 writes req_seed_word into state word req_word_index (0 is the
// most significant word; an index past the last word writes nothing).
// Result channel (rsp_): a block is STATE_BITS/64 words, most significant
// first, rsp_last_word set on the final one.
// Timing: a seed write completes as it is accepted. An advance runs the
// bit-serial multiplier over the whole state, one product bit per cycle,
// then hands out one word per cycle while the receiver does not stall.
// req_stall is high from the accepted advance until its last word sits
// in the output register; the next item may be accepted while that word
// still waits.
// A receiver stall holds the output register and pauses the word sequence.
// Reset loads the fixed seed into the state and empties the output; there
// is no clearing pass.
// ----------------------------------------------------------------------------
module quadratic_congruential_prng_512 #(
   parameter int STATE_BITS = qcg_pkg::STATE_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_operation,
   input  wire  [63:0] req_seed_word,
   input  wire  [2:0]  req_word_index,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_random_word,
   output logic        rsp_last_word
);

   localparam int NWORDS = STATE_BITS / qcg_pkg::WORD_BITS;
   localparam int WIDTH  = NWORDS * qcg_pkg::WORD_BITS;
   localparam int CW     = $clog2(WIDTH);
   localparam int WCW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam logic [WIDTH-1:0] RESET_STATE = qcg_pkg::SEED_VALUE[WIDTH-1:0];
   localparam logic [CW-1:0]    LAST_BIT    = CW'(WIDTH - 1);
   localparam logic [WCW-1:0]   LAST_WORD   = WCW'(NWORDS - 1);

   qcg_pkg::fsm_type       fsm_ff, fsm_in;
   qcg_pkg::mult_ctrl_type mult_ctrl;

   logic [WIDTH-1:0] state_ff, state_in;
   logic [WIDTH-1:0] ser_ff, ser_in;
   logic             prev_ff, prev_in;
   logic             bcarry_ff, bcarry_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WCW-1:0]   wcnt_ff, wcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_word_ff, rsp_word_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             three_bit;
   logic             b_bit;
   logic             b_carry;
   logic             prod_bit;
   logic             out_free;

   qcg_serial_mult #(
      .WIDTH (WIDTH)
   ) u_mult (
      .clock    (clock),
      .ctrl     (mult_ctrl),
      .x        (state_ff),
      .b_bit    (b_bit),
      .prod_bit (prod_bit)
   );

   always_comb begin
      // serial 2x+3: x delayed one bit plus a constant three
      three_bit = (cnt_ff[CW-1:1] == '0);
      b_bit     = prev_ff ^ three_bit ^ bcarry_ff;
      b_carry   = (prev_ff & three_bit) | (prev_ff & bcarry_ff) | (three_bit & bcarry_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;

      fsm_in       = fsm_ff;
      state_in     = state_ff;
      ser_in       = ser_ff;
      prev_in      = prev_ff;
      bcarry_in    = bcarry_ff;
      cnt_in       = cnt_ff;
      wcnt_in      = wcnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      mult_ctrl    = '0;

      unique case (fsm_ff)
         qcg_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == qcg_pkg::OP_SEED) begin
                  for (int w = 0; w < NWORDS; w++) begin
                     if (int'(req_word_index) == w) begin
                        state_in[WIDTH-1-w*qcg_pkg::WORD_BITS -: 64] = req_seed_word;
                     end
                  end
               end else begin
                  ser_in          = state_ff;
                  prev_in         = 1'b0;
                  bcarry_in       = 1'b0;
                  cnt_in          = '0;
                  mult_ctrl.clear = 1'b1;
                  fsm_in          = qcg_pkg::ST_CALC;
               end
            end
         end
         qcg_pkg::ST_CALC: begin
            // product bits enter at the top as the state copy leaves the bottom
            mult_ctrl.step = 1'b1;
            ser_in         = {prod_bit, ser_ff[WIDTH-1:1]};
            prev_in        = ser_ff[0];
            bcarry_in      = b_carry;
            cnt_in         = cnt_ff + CW'(1);
            if (cnt_ff == LAST_BIT) begin
               state_in = {prod_bit, ser_ff[WIDTH-1:1]};
               wcnt_in  = '0;
               fsm_in   = qcg_pkg::ST_EMIT;
            end
         end
         qcg_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = ser_ff[WIDTH-1 -: 64];
               rsp_last_in  = (wcnt_ff == LAST_WORD);
               ser_in       = ser_ff << qcg_pkg::WORD_BITS;
               wcnt_in      = wcnt_ff + WCW'(1);
               if (wcnt_ff == LAST_WORD) begin
                  fsm_in = qcg_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            fsm_in = qcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= qcg_pkg::ST_IDLE;
         state_ff     <= RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_ff      <= ser_in;
      prev_ff     <= prev_in;
      bcarry_ff   <= bcarry_in;
      cnt_ff      <= cnt_in;
      wcnt_ff     <= wcnt_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall       = (fsm_ff != qcg_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;
   assign rsp_last_word   = rsp_last_ff;

endmodule
`default_nettype wire

### hdl/qcg_serial_mult.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcg_serial_mult
// Serial-parallel multiplier with a carry-save accumulator. The parallel
// operand is held outside; while step is set the serial operand enters one
// bit per cycle, least significant first, and one product bit leaves per
// cycle. A clear presets the accumulator to one, so bits are those of x*b+1.
// ----------------------------------------------------------------------------
module qcg_serial_mult #(
   parameter int WIDTH = qcg_pkg::STATE_BITS_DEFAULT
) (
   input  wire                         clock,
   input  wire qcg_pkg::mult_ctrl_type ctrl,
   input  wire  [WIDTH-1:0]            x,
   input  wire                         b_bit,
   output logic                        prod_bit
);

   logic [WIDTH-1:0] sum_ff, sum_in;
   logic [WIDTH-1:0] carry_ff, carry_in;
   logic [WIDTH-1:0] pp;
   logic [WIDTH-1:0] t;
   logic [WIDTH-1:0] u;

   always_comb begin
      pp       = x & {WIDTH{b_bit}};
      t        = sum_ff ^ carry_ff ^ pp;
      u        = (sum_ff & carry_ff) | (sum_ff & pp) | (carry_ff & pp);
      prod_bit = t[0];
      sum_in   = sum_ff;
      carry_in = carry_ff;
      if (ctrl.clear) begin
         sum_in   = '0;
         carry_in = WIDTH'(1);
      end else if (ctrl.step) begin
         // halve the accumulator after the low bit has left
         sum_in   = {1'b0, t[WIDTH-1:1]};
         carry_in = u;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
   end

endmodule
`default_nettype wire

### hdl/qcg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcg_checker
// Port-level checks of the generator: result hold under stall, busy
// signalling around an advance and spacing between blocks.
// ----------------------------------------------------------------------------
module qcg_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        req_operation,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [63:0] rsp_random_word,
   input wire        rsp_last_word
);

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_random_word)
                                    && $stable(rsp_last_word)))
      else $error("stalled result item changed");

   // an accepted advance makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_operation) |=> req_stall)
      else $error("advance accepted without going busy");

   // a seed write completes at once
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation) |=> !req_stall)
      else $error("seed write left the block busy");

   // results only start while an advance is running
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without a running advance");

   // the next block needs the whole multiply first
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> !rsp_valid)
      else $error("result item right after the last word of a block");

endmodule

bind quadratic_congruential_prng_512 qcg_checker u_qcg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_random_word (rsp_random_word),
   .rsp_last_word   (rsp_last_word)
);
`default_nettype wire

### test/quadratic_congruential_prng_512_tb.sv
// ----------------------------------------------------------------------------
// quadratic_congruential_prng_512_tb
// Self-checking bench for the 512-bit quadratic congruential generator.
// A scoreboard keeps its own copy of the 512-bit state. It applies seed
// writes and advances (x <- x*(2x+3)+1 mod 2^512) in the order the block
// takes them, and compares every emitted word and last flag in order.
// A short directed run comes first: reset seed, all-zero and all-ones states.
// Random items follow under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module quadratic_congruential_prng_512_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GEN_BITS    = 512;
   localparam int GEN_WORDS   = GEN_BITS / 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_TAIL  = 600;

   localparam logic [GEN_BITS-1:0] POWER_ON_SEED = {
      64'h7844506a9456c564, 64'hb8b8538e0cc15aff,
      64'h46c95e69600f084f, 64'h0657c2401b3c2447,
      64'h34b62ea9bb95be49, 64'h23b9b7e84eeaf1a2,
      64'h24894ef0328d44bc, 64'h3eb3e983644da3f5
   };

   typedef struct packed {
      logic [63:0] word;
      logic        last;
   } block_word_type;

   class prng_scoreboard;
      logic [GEN_BITS-1:0] gen_state;
      block_word_type      block_q[$];
      int                  errors;

      function new();
         gen_state = POWER_ON_SEED;
         errors    = 0;
      endfunction

      function void note_request(logic op, logic [63:0] seed, logic [2:0] idx);
         logic [GEN_BITS-1:0] factor;
         block_word_type      bw;
         int                  slot;
         if (op == qcg_pkg::OP_SEED) begin
            // word 0 is the most significant
            slot = GEN_WORDS - 1 - int'(idx);
            gen_state[slot*64 +: 64] = seed;
         end else begin
            factor    = (gen_state << 1) + 3;
            gen_state = gen_state * factor + 1;
            for (int w = 0; w < GEN_WORDS; w++) begin
               bw.word = gen_state[(GEN_WORDS-1-w)*64 +: 64];
               bw.last = (w == GEN_WORDS - 1);
               block_q.push_back(bw);
            end
         end
      endfunction

      function void check_word(logic [63:0] word, logic last);
         block_word_type exp_bw;
         if (block_q.size() == 0) begin
            $display("%0t: unexpected item, actual word %h last %b", $time, word, last);
            errors++;
         end else begin
            exp_bw = block_q.pop_front();
            if (word !== exp_bw.word) begin
               $display("%0t: random_word mismatch, expected %h, actual %h",
                        $time, exp_bw.word, word);
               errors++;
            end
            if (last !== exp_bw.last) begin
               $display("%0t: last_word mismatch, expected %b, actual %b",
                        $time, exp_bw.last, last);
               errors++;
            end
         end
      endfunction

      function bit idle();
         return block_q.size() == 0;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = qcg_pkg::OP_ADVANCE;
   logic [63:0] req_seed_word = '0;
   logic [2:0]  req_word_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_random_word;
   logic        rsp_last_word;

   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             cycle_count = 0;
   prng_scoreboard sb = new();

   quadratic_congruential_prng_512 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_seed_word   (req_seed_word),
      .req_word_index  (req_word_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quadratic_congruential_prng_512 verification failed");
         $finish;
      end
   end

   // receiver: check accepted words, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_random_word, rsp_last_word);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_item(input logic op, input logic [63:0] seed,
                            input logic [2:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_seed_word  <= seed;
      req_word_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, seed, idx);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!sb.idle()) @(posedge clock);
   endtask

   task automatic fill_state(input logic [63:0] value);
      for (int w = 0; w < GEN_WORDS; w++)
         send_item(qcg_pkg::OP_SEED, value, 3'(w));
   endtask

   task automatic run_random(input int count);
      logic op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(99) < 60) ? qcg_pkg::OP_ADVANCE : qcg_pkg::OP_SEED;
         send_item(op, {$urandom, $urandom}, 3'($urandom_range(7)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on seed, with junk in the fields an advance ignores
      send_item(qcg_pkg::OP_ADVANCE, '1, 3'd7);
      // zero state goes to one, then onward
      fill_state('0);
      send_item(qcg_pkg::OP_ADVANCE, '0, 3'd0);
      send_item(qcg_pkg::OP_ADVANCE, 64'h5a5a_5a5a_5a5a_5a5a, 3'd5);
      // all ones is -1, which maps to zero
      fill_state('1);
      send_item(qcg_pkg::OP_ADVANCE, '0, 3'd0);
      send_item(qcg_pkg::OP_SEED, 64'h8000_0000_0000_0001, 3'd3);
      send_item(qcg_pkg::OP_ADVANCE, '1, 3'd3);
      hold_until_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(20);
      hold_until_drained();

      send_idle_pct  = 63;
      recv_stall_pct = 0;
      run_random(20);

      send_idle_pct  = 0;
      recv_stall_pct = 63;
      run_random(20);
      hold_until_drained();

      send_idle_pct  = 21;
      recv_stall_pct = 21;
      run_random(20);

      hold_until_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.errors == 0 && sb.idle())
         $display("quadratic_congruential_prng_512 verification clean");
      else
         $display("quadratic_congruential_prng_512 verification failed");
      $finish;
   end

endmodule
